/* rtl/qrgs_pkg.sv */
// Shared types, sizes and arithmetic helpers for the 3x3 Gram-Schmidt QR block.
// Used by qrgs_div and the top level qr_gram_schmidt_3x3; depends on nothing.
package qrgs_pkg;

  localparam int MATRIX_SIZE = 3;
  localparam int NUM_Q       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int NUM_R       = (MATRIX_SIZE * (MATRIX_SIZE + 1)) / 2;
  localparam int RC_W        = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int QA_W        = $clog2(NUM_Q);
  localparam int RA_W        = (NUM_R > 1) ? $clog2(NUM_R) : 1;

  // field widths
  localparam int IDX_W   = 2;
  localparam int ELEM_W  = 16;
  localparam int ENTRY_W = 24;
  localparam int V_W     = 34;
  localparam int NUM_W   = 49;
  localparam int DEN_W   = 23;

  localparam logic signed [32:0] MAX24 = 33'sd8388607;
  localparam logic signed [32:0] MIN24 = -33'sd8388608;

  typedef enum logic [4:0] {
    S_IDLE, S_LV_RD, S_LV_CAP,
    S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_R_WR,
    S_SUB_RD, S_SUB_MUL, S_SUB_ACC,
    S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT, S_DIAG,
    S_DIV_GO, S_DIV_WAIT, S_Q_WR,
    S_EM_RD, S_EM_CAP, S_EM_OUT
  } state_t;

  // row-major address of element (r, c)
  function automatic logic [QA_W-1:0] elem_idx(input logic [RC_W-1:0] r,
                                               input logic [RC_W-1:0] c);
    return QA_W'(int'(r) * MATRIX_SIZE + int'(c));
  endfunction

  // address of R entry (r, c), c >= r, upper triangle row-major
  function automatic logic [RA_W-1:0] tri_idx(input logic [RC_W-1:0] r,
                                              input logic [RC_W-1:0] c);
    int ri;
    int ci;
    ri = int'(r);
    ci = int'(c);
    return RA_W'(ri * MATRIX_SIZE - (ri * (ri - 1)) / 2 + (ci - ri));
  endfunction

  // Q.32 to Q.16, round to nearest with ties away from zero
  function automatic logic signed [32:0] round_q16(input logic signed [47:0] x);
    logic [47:0] m;
    logic [31:0] r;
    m = x[47] ? 48'(-x) : 48'(x);
    r = 32'((m + 48'd32768) >> 16);
    return x[47] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic signed [ENTRY_W-1:0] sat24(input logic signed [32:0] x);
    logic signed [32:0] y;
    y = x;
    if (x > MAX24) y = MAX24;
    if (x < MIN24) y = MIN24;
    return y[ENTRY_W-1:0];
  endfunction

endpackage

/* rtl/qrgs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qrgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/qrgs_sqrt.sv */
// Floor integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing beyond the clock and reset.
module qrgs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem[33:0], n[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one result bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      n <= {n[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/qrgs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses qrgs_pkg for operand widths.
module qrgs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qrgs_pkg::NUM_W-1:0]  num,
  input  logic [qrgs_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [qrgs_pkg::NUM_W-1:0]  quot
);

  logic [qrgs_pkg::DEN_W-1:0] dreg;
  logic [qrgs_pkg::DEN_W-1:0] rem;
  logic [qrgs_pkg::DEN_W:0]   rem_sh;
  logic [5:0]                 cnt;
  logic                       busy;

  assign rem_sh = {rem, quot[qrgs_pkg::NUM_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(qrgs_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dreg}) begin
        rem  <= qrgs_pkg::DEN_W'(rem_sh - {1'b0, dreg});
        quot <= {quot[qrgs_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[qrgs_pkg::DEN_W-1:0];
        quot <= {quot[qrgs_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/qr_gram_schmidt_3x3.sv */
// Top level of the 3x3 classical Gram-Schmidt QR block: sequencer, stores, output.
// Depends on qrgs_pkg, qrgs_ram, qrgs_sqrt and qrgs_div.

// Elements are loaded one item per cycle while the block is idle; the item
// with tlast set starts the decomposition and the block takes no input until
// all 15 results (Q row-major, then the upper triangle of R row-major) have
// been taken. For each column the block loads it, forms the dot product with
// each earlier column, stores that R entry and subtracts the projection, sums
// the squares, takes the bit-pair square root, stores the diagonal and runs
// the bit-serial divider per row (not when the norm is zero), which dominates;
// each of the 15 results is then read and presented, waiting on output stalls.
// The element store reads as zero until written and keeps its contents across matrices.
module qr_gram_schmidt_3x3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row[1:0], col[3:2], value[19:4], zero pad
  input  logic        s_tlast,   // last: start decomposition
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_row[1:0], out_col[3:2], entry[27:4],
                                 // rank_deficient[28], zero pad
  output logic        m_tuser,   // which_matrix: 0 = Q, 1 = R
  output logic        m_tlast    // final_res
);

  localparam int N = qrgs_pkg::MATRIX_SIZE;
  localparam logic [qrgs_pkg::RC_W-1:0] LAST_RC = qrgs_pkg::RC_W'(N - 1);

  qrgs_pkg::state_t state, state_next;

  logic [qrgs_pkg::RC_W-1:0] i, j, k, er, ec;
  logic                      which;
  logic                      flag;

  // input fields
  logic [qrgs_pkg::IDX_W-1:0]  in_row, in_col;
  logic [qrgs_pkg::ELEM_W-1:0] in_value;
  logic                        in_acc, elem_we;

  assign in_row   = s_tdata[1:0];
  assign in_col   = s_tdata[3:2];
  assign in_value = s_tdata[19:4];
  assign s_tready = (state == qrgs_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign elem_we  = in_acc && (int'(in_row) < N) && (int'(in_col) < N);

  // element store with valid bits
  logic [qrgs_pkg::NUM_Q-1:0]  elem_vld;
  logic                        elem_vld_q;
  logic [qrgs_pkg::QA_W-1:0]   elem_waddr, elem_raddr;
  logic [qrgs_pkg::ELEM_W-1:0] elem_rdata, elem_a;

  assign elem_waddr = qrgs_pkg::elem_idx(qrgs_pkg::RC_W'(in_row), qrgs_pkg::RC_W'(in_col));
  assign elem_raddr = qrgs_pkg::elem_idx(i, j);
  assign elem_a     = elem_vld_q ? elem_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_vld <= '0;
    end else if (elem_we) begin
      elem_vld[elem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    elem_vld_q <= elem_vld[elem_raddr];
  end

  qrgs_ram #(.WIDTH(qrgs_pkg::ELEM_W), .DEPTH(qrgs_pkg::NUM_Q)) u_elem (
    .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(in_value),
    .raddr(elem_raddr), .rdata(elem_rdata)
  );

  // basis (Q) and triangle (R) stores
  logic                         basis_we, tri_we;
  logic [qrgs_pkg::QA_W-1:0]    basis_raddr;
  logic [qrgs_pkg::RA_W-1:0]    tri_waddr, tri_raddr;
  logic [qrgs_pkg::ENTRY_W-1:0] basis_wdata, basis_rdata, tri_wdata, tri_rdata;

  assign basis_raddr = (state == qrgs_pkg::S_EM_RD) ? qrgs_pkg::elem_idx(er, ec)
                                                    : qrgs_pkg::elem_idx(i, k);
  assign tri_raddr   = qrgs_pkg::tri_idx(er, ec);

  qrgs_ram #(.WIDTH(qrgs_pkg::ENTRY_W), .DEPTH(qrgs_pkg::NUM_Q)) u_basis (
    .clk(clk), .we(basis_we), .waddr(qrgs_pkg::elem_idx(i, j)), .wdata(basis_wdata),
    .raddr(basis_raddr), .rdata(basis_rdata)
  );

  qrgs_ram #(.WIDTH(qrgs_pkg::ENTRY_W), .DEPTH(qrgs_pkg::NUM_R)) u_tri (
    .clk(clk), .we(tri_we), .waddr(tri_waddr), .wdata(tri_wdata),
    .raddr(tri_raddr), .rdata(tri_rdata)
  );

  // datapath registers
  localparam int V_W_T = qrgs_pkg::V_W;
  logic signed [V_W_T-1:0] v [N];
  logic signed [43:0]                 prod_dot;
  logic signed [45:0]                 acc;
  logic signed [47:0]                 prod_sub;
  logic signed [qrgs_pkg::ENTRY_W-1:0] rreg;
  logic [63:0]                        sqp, sq;
  logic [qrgs_pkg::DEN_W-1:0]         dreg;

  logic signed [19:0]                 a20;
  logic signed [qrgs_pkg::ENTRY_W-1:0] r_new;
  logic [31:0]                        vabs;
  logic [qrgs_pkg::DEN_W-1:0]         d_new;
  logic signed [qrgs_pkg::ENTRY_W-1:0] q_new;
  logic signed [32:0]                 sub_rnd;

  // square root and divider units
  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0] root;
  logic [qrgs_pkg::NUM_W-1:0] div_num, quot;

  qrgs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sq),
    .done(sqrt_done), .root(root)
  );

  qrgs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(dreg),
    .done(div_done), .quot(quot)
  );

  assign a20     = {elem_a, 4'b0000};
  assign r_new   = qrgs_pkg::sat24(qrgs_pkg::round_q16({{2{acc[45]}}, acc}));
  assign vabs    = v[i][V_W_T-1] ? 32'(-v[i]) : 32'(v[i]);
  assign d_new   = (root > 32'(qrgs_pkg::MAX24)) ? qrgs_pkg::DEN_W'(qrgs_pkg::MAX24)
                                                 : root[qrgs_pkg::DEN_W-1:0];
  assign div_num = {1'b0, vabs, 16'h0000} + qrgs_pkg::NUM_W'(dreg[qrgs_pkg::DEN_W-1:1]);
  assign sub_rnd = qrgs_pkg::round_q16(prod_sub);

  // signed saturation of the quotient magnitude, zero when the norm is zero
  always_comb begin
    q_new = '0;
    if (dreg != '0) begin
      if (v[i][V_W_T-1]) begin
        if (quot > qrgs_pkg::NUM_W'(24'h800000)) begin
          q_new = qrgs_pkg::sat24(qrgs_pkg::MIN24);
        end else begin
          q_new = -$signed(quot[qrgs_pkg::ENTRY_W-1:0]);
        end
      end else if (quot > qrgs_pkg::NUM_W'(qrgs_pkg::MAX24)) begin
        q_new = qrgs_pkg::sat24(qrgs_pkg::MAX24);
      end else begin
        q_new = $signed(quot[qrgs_pkg::ENTRY_W-1:0]);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qrgs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, store strobes and square root / divider start strobes
  always_comb begin
    state_next  = state;
    basis_we    = 1'b0;
    basis_wdata = q_new;
    tri_we      = 1'b0;
    tri_waddr   = qrgs_pkg::tri_idx(k, j);
    tri_wdata   = r_new;
    sqrt_start  = 1'b0;
    div_start   = 1'b0;
    case (state)
      qrgs_pkg::S_IDLE:      if (in_acc && s_tlast) state_next = qrgs_pkg::S_LV_RD;
      qrgs_pkg::S_LV_RD:     state_next = qrgs_pkg::S_LV_CAP;
      qrgs_pkg::S_LV_CAP: begin
        if (i != LAST_RC) state_next = qrgs_pkg::S_LV_RD;
        else if (j == '0) state_next = qrgs_pkg::S_SQ_MUL;
        else              state_next = qrgs_pkg::S_DOT_RD;
      end
      qrgs_pkg::S_DOT_RD:    state_next = qrgs_pkg::S_DOT_MUL;
      qrgs_pkg::S_DOT_MUL:   state_next = qrgs_pkg::S_DOT_ACC;
      qrgs_pkg::S_DOT_ACC:   state_next = (i == LAST_RC) ? qrgs_pkg::S_R_WR
                                                         : qrgs_pkg::S_DOT_RD;
      qrgs_pkg::S_R_WR: begin
        tri_we     = 1'b1;
        state_next = qrgs_pkg::S_SUB_RD;
      end
      qrgs_pkg::S_SUB_RD:    state_next = qrgs_pkg::S_SUB_MUL;
      qrgs_pkg::S_SUB_MUL:   state_next = qrgs_pkg::S_SUB_ACC;
      qrgs_pkg::S_SUB_ACC: begin
        if (i != LAST_RC)      state_next = qrgs_pkg::S_SUB_RD;
        else if (k == j - 1'b1) state_next = qrgs_pkg::S_SQ_MUL;
        else                   state_next = qrgs_pkg::S_DOT_RD;
      end
      qrgs_pkg::S_SQ_MUL:    state_next = qrgs_pkg::S_SQ_ACC;
      qrgs_pkg::S_SQ_ACC:    state_next = (i == LAST_RC) ? qrgs_pkg::S_SQRT_GO
                                                         : qrgs_pkg::S_SQ_MUL;
      qrgs_pkg::S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = qrgs_pkg::S_SQRT_WAIT;
      end
      qrgs_pkg::S_SQRT_WAIT: if (sqrt_done) state_next = qrgs_pkg::S_DIAG;
      qrgs_pkg::S_DIAG: begin
        tri_we     = 1'b1;
        tri_waddr  = qrgs_pkg::tri_idx(j, j);
        tri_wdata  = {1'b0, d_new};
        state_next = qrgs_pkg::S_DIV_GO;
      end
      qrgs_pkg::S_DIV_GO: begin
        if (dreg == '0) begin
          state_next = qrgs_pkg::S_Q_WR;
        end else begin
          div_start  = 1'b1;
          state_next = qrgs_pkg::S_DIV_WAIT;
        end
      end
      qrgs_pkg::S_DIV_WAIT:  if (div_done) state_next = qrgs_pkg::S_Q_WR;
      qrgs_pkg::S_Q_WR: begin
        basis_we = 1'b1;
        if (i != LAST_RC)      state_next = qrgs_pkg::S_DIV_GO;
        else if (j != LAST_RC) state_next = qrgs_pkg::S_LV_RD;
        else                   state_next = qrgs_pkg::S_EM_RD;
      end
      qrgs_pkg::S_EM_RD:     state_next = qrgs_pkg::S_EM_CAP;
      qrgs_pkg::S_EM_CAP:    state_next = qrgs_pkg::S_EM_OUT;
      qrgs_pkg::S_EM_OUT: begin
        if (m_tready) begin
          state_next = m_tlast ? qrgs_pkg::S_IDLE : qrgs_pkg::S_EM_RD;
        end
      end
      default:               state_next = qrgs_pkg::S_IDLE;
    endcase
  end

  // loop counters and deficiency flag
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      j     <= '0;
      k     <= '0;
      er    <= '0;
      ec    <= '0;
      which <= 1'b0;
      flag  <= 1'b0;
    end else begin
      case (state)
        qrgs_pkg::S_IDLE: begin
          if (in_acc && s_tlast) begin
            i    <= '0;
            j    <= '0;
            flag <= 1'b0;
          end
        end
        qrgs_pkg::S_LV_CAP: begin
          i <= (i == LAST_RC) ? '0 : i + 1'b1;
          k <= '0;
        end
        qrgs_pkg::S_DOT_ACC, qrgs_pkg::S_SQ_ACC: i <= (i == LAST_RC) ? '0 : i + 1'b1;
        qrgs_pkg::S_SUB_ACC: begin
          if (i == LAST_RC) begin
            i <= '0;
            k <= k + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        qrgs_pkg::S_DIAG: begin
          i <= '0;
          if (d_new == '0) flag <= 1'b1;
        end
        qrgs_pkg::S_Q_WR: begin
          if (i == LAST_RC) begin
            i <= '0;
            if (j != LAST_RC) begin
              j <= j + 1'b1;
            end else begin
              er    <= '0;
              ec    <= '0;
              which <= 1'b0;
            end
          end else begin
            i <= i + 1'b1;
          end
        end
        qrgs_pkg::S_EM_OUT: begin
          if (m_tready) begin
            if (ec != LAST_RC) begin
              ec <= ec + 1'b1;
            end else if (!which) begin
              if (er == LAST_RC) begin
                which <= 1'b1;
                er    <= '0;
                ec    <= '0;
              end else begin
                er <= er + 1'b1;
                ec <= '0;
              end
            end else begin
              er <= er + 1'b1;
              ec <= er + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (state)
      qrgs_pkg::S_LV_RD:   sq <= '0;
      qrgs_pkg::S_LV_CAP:  v[i] <= {{(V_W_T - 20){elem_a[15]}}, elem_a, 4'b0000};
      qrgs_pkg::S_DOT_RD:  if (i == '0) acc <= '0;
      qrgs_pkg::S_DOT_MUL: prod_dot <= $signed(basis_rdata) * a20;
      qrgs_pkg::S_DOT_ACC: acc <= acc + {{2{prod_dot[43]}}, prod_dot};
      qrgs_pkg::S_R_WR:    rreg <= r_new;
      qrgs_pkg::S_SUB_MUL: prod_sub <= rreg * $signed(basis_rdata);
      qrgs_pkg::S_SUB_ACC: v[i] <= v[i] - {sub_rnd[32], sub_rnd};
      qrgs_pkg::S_SQ_MUL:  sqp <= vabs * vabs;
      qrgs_pkg::S_SQ_ACC:  sq <= sq + sqp;
      qrgs_pkg::S_DIAG:    dreg <= d_new;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == qrgs_pkg::S_EM_CAP) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qrgs_pkg::S_EM_CAP) begin
      m_tdata <= {3'b000, flag, (which ? tri_rdata : basis_rdata),
                  qrgs_pkg::IDX_W'(ec), qrgs_pkg::IDX_W'(er)};
      m_tuser <= which;
      m_tlast <= which && (er == LAST_RC) && (ec == LAST_RC);
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while a result is pending");
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> state == qrgs_pkg::S_LV_RD)
    else $error("last item did not start the decomposition");
  a_sqrt: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == qrgs_pkg::S_SQRT_WAIT) else $error("stray root");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == qrgs_pkg::S_DIV_WAIT) else $error("stray quotient");
  a_last_r: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser) else $error("final result is not an R entry");

endmodule

/* tb/qr_gram_schmidt_3x3_tb.sv */
// Self-checking bench for the 3x3 Gram-Schmidt QR block: element items in, Q and R items out.
// Depends on the RTL top qr_gram_schmidt_3x3; an internal QR predictor checks
// every result item.
module qr_gram_schmidt_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [15:0] value;
    logic        last;
  } elem_item_t;

  typedef struct packed {
    logic        which;
    logic [1:0]  orow;
    logic [1:0]  ocol;
    logic [23:0] entry;
    logic        defic;
    logic        fin;
  } qr_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  qr_gram_schmidt_3x3 i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint     elem_mem [9];
  longint     basis_mem [9];
  longint     tri_mem [6];
  bit         defic_flag;
  qr_item_t   qr_expected [$];
  int         fail_count = 0;
  longint     cycle_count = 0;

  function automatic longint clip24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic longint round_to_q16(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + 32768) >>> 16;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic int tri_pos(int i, int j);
    return i * 3 - (i * (i - 1)) / 2 + (j - i);
  endfunction

  // Gram-Schmidt over the current element store
  task automatic decompose_matrix();
    longint v [3];
    longint unsigned sq;
    longint d, acc, r, m, q;
    defic_flag = 1'b0;
    for (int j = 0; j < 3; j++) begin
      sq = 0;
      for (int i = 0; i < 3; i++) v[i] = elem_mem[i*3+j] * 16;
      for (int k = 0; k < j; k++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += basis_mem[i*3+k] * (elem_mem[i*3+j] * 16);
        r = clip24(round_to_q16(acc));
        tri_mem[tri_pos(k, j)] = r;
        for (int i = 0; i < 3; i++) v[i] -= round_to_q16(r * basis_mem[i*3+k]);
      end
      for (int i = 0; i < 3; i++) begin
        m = (v[i] < 0) ? -v[i] : v[i];
        sq += longint'(m) * longint'(m);
      end
      d = clip24(int_sqrt(sq));
      tri_mem[tri_pos(j, j)] = d;
      for (int i = 0; i < 3; i++) begin
        q = 0;
        if (d != 0) begin
          m = (v[i] < 0) ? -v[i] : v[i];
          m = (m * 65536 + d / 2) / d;
          q = clip24((v[i] < 0) ? -m : m);
        end
        basis_mem[i*3+j] = q;
      end
      if (d == 0) defic_flag = 1'b1;
    end
  endtask

  // store the element; on last, queue the 15 expected entries
  task automatic predict_qr(elem_item_t it);
    qr_item_t e;
    int n;
    if (it.row < 3 && it.col < 3) elem_mem[it.row*3+it.col] = longint'($signed(it.value));
    if (!it.last) return;
    decompose_matrix();
    n = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = '{1'b0, 2'(i), 2'(j), 24'(basis_mem[i*3+j]), defic_flag, 1'b0};
        qr_expected.push_back(e);
      end
    for (int i = 0; i < 3; i++)
      for (int j = i; j < 3; j++) begin
        n++;
        e = '{1'b1, 2'(i), 2'(j), 24'(tri_mem[tri_pos(i, j)]), defic_flag, n == 6};
        qr_expected.push_back(e);
      end
  endtask

  // directed table; entry col is typed-in expectation for first Q entry, check flag marks use
  typedef struct {
    elem_item_t it;
    bit         typed;
    logic [23:0] q00;
  } dir_row_t;

  dir_row_t dir_table [$];
  qr_item_t typed_q00 [$];

  // result checker
  always @(posedge clk) begin
    qr_item_t e, a;
    if (!rst) cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      a = '{m_tuser, m_tdata[1:0], m_tdata[3:2], m_tdata[27:4], m_tdata[28], m_tlast};
      if (qr_expected.size() == 0) begin
        $error("unexpected result item %h", a);
        fail_count++;
      end else begin
        e = qr_expected.pop_front();
        if (a.which !== e.which) begin
          $error("which_matrix exp %0d got %0d", e.which, a.which);
          fail_count++;
        end
        if (a.orow !== e.orow) begin
          $error("out_row exp %0d got %0d", e.orow, a.orow);
          fail_count++;
        end
        if (a.ocol !== e.ocol) begin
          $error("out_col exp %0d got %0d", e.ocol, a.ocol);
          fail_count++;
        end
        if (a.entry !== e.entry) begin
          $error("entry exp %h got %h", e.entry, a.entry);
          fail_count++;
        end
        if (a.defic !== e.defic) begin
          $error("rank_deficient exp %0d got %0d", e.defic, a.defic);
          fail_count++;
        end
        if (a.fin !== e.fin) begin
          $error("final_res exp %0d got %0d", e.fin, a.fin);
          fail_count++;
        end
        if (typed_q00.size() != 0 && e.which == 1'b0 && e.orow == 0 && e.ocol == 0) begin
          if (a.entry !== typed_q00[0].entry) begin
            $error("entry exp %h got %h", typed_q00[0].entry, a.entry);
            fail_count++;
          end
          void'(typed_q00.pop_front());
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int w;
    @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      m_tready <= 1'b0;
      repeat (w) @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // timeout
  initial begin
    wait (cycle_count > 64'd2000000);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_elem(elem_item_t it, bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 17);
    if (w != 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.value, it.col, it.row};
    s_tlast  <= it.last;
    predict_qr(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic elem_item_t mk(int r, int c, int v, bit l);
    elem_item_t it;
    it.row = 2'(r); it.col = 2'(c); it.value = 16'(v); it.last = l;
    return it;
  endfunction

  initial begin
    elem_item_t it;
    qr_item_t tq;
    int burst;
    for (int i = 0; i < 9; i++) elem_mem[i] = 0;
    defic_flag = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // after reset: all-zero matrix, every column deficient, Q(0,0) = 0
    dir_table.push_back('{mk(0, 0, 0, 1), 1'b1, 24'h0});
    // identity with 0x1000 = 1.0 in Q4.12 on the diagonal: Q(0,0) = 1.0 in Q8.16
    dir_table.push_back('{mk(0, 0, 16'h1000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 1, 16'h1000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(2, 2, 16'h1000, 1), 1'b1, 24'h010000});
    // extremes of value
    dir_table.push_back('{mk(0, 0, 16'h7FFF, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 1, 16'h8000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(2, 2, 16'h7FFF, 1), 1'b1, 24'h010000});
    dir_table.push_back('{mk(0, 1, 16'h8000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 0, 16'hFFFF, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(2, 1, 16'h0001, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 2, 16'h8000, 1), 1'b0, 24'h0});
    // out-of-range indices: not stored, last still decomposes
    dir_table.push_back('{mk(3, 0, 16'h1234, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(0, 3, 16'h5678, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(3, 3, 16'hABCD, 1), 1'b0, 24'h0});
    // duplicate column: rank deficient
    dir_table.push_back('{mk(0, 0, 16'h1000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(0, 1, 16'h1000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 0, 16'h0000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(1, 1, 16'h0000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(2, 0, 16'h0000, 0), 1'b0, 24'h0});
    dir_table.push_back('{mk(2, 1, 16'h0000, 1), 1'b0, 24'h0});
    foreach (dir_table[i]) begin
      if (dir_table[i].typed) begin
        tq = '0;
        tq.entry = dir_table[i].q00;
        typed_q00.push_back(tq);
      end
      send_elem(dir_table[i].it, 1'b0);
    end

    // pause until the block has delivered everything
    s_tvalid <= 1'b0;
    wait (qr_expected.size() == 0);
    @(negedge clk);

    // random: mostly complete matrices, some partial loads and stray indices
    for (int n = 0; n < 210; ) begin
      if ($urandom_range(0, 4) != 0) begin
        burst = $urandom_range(0, 3) == 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) begin
            it = mk(r, c, $urandom, (r == 2 && c == 2));
            if ($urandom_range(0, 5) == 0) it.value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 7) == 0) it.value = 16'($signed(4'($urandom)));
            send_elem(it, burst);
            n++;
          end
      end else begin
        it = $urandom;
        send_elem(it, 1'b0);
        n++;
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    wait (qr_expected.size() == 0);
    repeat (800) @(negedge clk);
    if (fail_count == 0 && qr_expected.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/qrgs_pkg.sv
rtl/qrgs_ram.sv
rtl/qrgs_sqrt.sv
rtl/qrgs_div.sv
rtl/qr_gram_schmidt_3x3.sv
tb/qr_gram_schmidt_3x3_tb.sv
